>>> sv/tcbf_pkg.sv
// Package for the Thai cluster boundary finder.
// Holds code point classes, cluster phase codes and the result push bundle.
// No dependencies.
`timescale 1ns / 1ps

package tcbf_pkg;

    localparam int unsigned CP_WIDTH = 21;

    localparam logic [CP_WIDTH-1:0] CP_CONS_LO    = 21'h000E01;
    localparam logic [CP_WIDTH-1:0] CP_CONS_HI    = 21'h000E2E;
    localparam logic [CP_WIDTH-1:0] CP_FOLLOW_LO  = 21'h000E30;
    localparam logic [CP_WIDTH-1:0] CP_FOLLOW_HI  = 21'h000E33;
    localparam logic [CP_WIDTH-1:0] CP_ABOVE_LO   = 21'h000E34;
    localparam logic [CP_WIDTH-1:0] CP_ABOVE_HI   = 21'h000E37;
    localparam logic [CP_WIDTH-1:0] CP_BELOW_LO   = 21'h000E38;
    localparam logic [CP_WIDTH-1:0] CP_BELOW_HI   = 21'h000E39;
    localparam logic [CP_WIDTH-1:0] CP_LEAD_LO    = 21'h000E40;
    localparam logic [CP_WIDTH-1:0] CP_LEAD_HI    = 21'h000E44;
    localparam logic [CP_WIDTH-1:0] CP_TONE_LO    = 21'h000E48;
    localparam logic [CP_WIDTH-1:0] CP_SIGN_HI    = 21'h000E4E;

    typedef enum logic [2:0] {
        CL_OTHER  = 3'd0,
        CL_LEAD   = 3'd1,
        CL_CONS   = 3'd2,
        CL_MARK   = 3'd3,
        CL_FOLLOW = 3'd4
    } t_cp_class;

    typedef enum logic [5:0] {
        PH_IDLE       = 6'b000001,
        PH_LEAD       = 6'b000010,
        PH_LEAD_C1    = 6'b000100,
        PH_LEAD_MARKS = 6'b001000,
        PH_CONS_C1    = 6'b010000,
        PH_CONS_MARKS = 6'b100000
    } t_phase;

    typedef struct packed {
        logic valid0;
        logic fin0;
        logic valid1;
        logic fin1;
    } t_push;

    typedef struct packed {
        logic out_valid;
        logic spill_valid;
    } t_buf_status;

    function automatic t_cp_class cp_class(input logic [CP_WIDTH-1:0] cp);
        t_cp_class cls;
        if (cp >= CP_LEAD_LO && cp <= CP_LEAD_HI) begin
            cls = CL_LEAD;
        end else if (cp >= CP_CONS_LO && cp <= CP_CONS_HI) begin
            cls = CL_CONS;
        end else if ((cp >= CP_TONE_LO && cp <= CP_SIGN_HI) ||
                     (cp >= CP_ABOVE_LO && cp <= CP_BELOW_HI)) begin
            cls = CL_MARK;
        end else if (cp >= CP_FOLLOW_LO && cp <= CP_FOLLOW_HI) begin
            cls = CL_FOLLOW;
        end else begin
            cls = CL_OTHER;
        end
        return cls;
    endfunction

endpackage

>>> sv/thai_cluster_boundary_finder.sv
// Top level of the Thai cluster boundary finder.
// Depends on tcbf_pkg, tcbf_utf8_decoder, tcbf_cluster_tracker, tcbf_out_buffer.
`timescale 1ns / 1ps

// The block takes one byte of UTF-8 text per cycle when ready and reports, as
// one item each, the byte offsets at which simplified Thai character clusters
// end; the boundary flagged final comes with the last byte of the text. A byte
// passes the input register, is decoded and classified when the input stage
// fires, and its boundaries pass the result register. One byte normally yields
// at most one boundary, and then the block sustains one byte per cycle while
// results are taken. A byte that yields two boundaries holds the second in a
// spill register, and the input stage waits until the result register passes
// it on. After the final byte, decoder and tracker state return to reset values.
module thai_cluster_boundary_finder #(
    parameter int unsigned POSITION_WIDTH = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_text_valid,
    output logic                      o_text_ready,
    input  logic [7:0]                i_text_byte,
    input  logic                      i_end_of_text,
    output logic                      o_result_valid,
    input  logic                      i_result_ready,
    output logic [POSITION_WIDTH-1:0] o_boundary_position,
    output logic                      o_final_boundary
);
    import tcbf_pkg::*;

    logic                      r_in_valid;
    logic [7:0]                r_in_byte;
    logic                      r_in_last;
    logic                      fire;
    logic                      complete;
    logic [CP_WIDTH-1:0]       codepoint;
    t_push                     push;
    t_buf_status               buf_status;
    logic [POSITION_WIDTH-1:0] pos0;
    logic [POSITION_WIDTH-1:0] pos1;

    assign fire = r_in_valid && !buf_status.spill_valid &&
                  (!buf_status.out_valid || i_result_ready);
    assign o_text_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_text_ready) begin
            r_in_valid <= i_text_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_text_ready && i_text_valid) begin
            r_in_byte <= i_text_byte;
            r_in_last <= i_end_of_text;
        end
    end

    tcbf_utf8_decoder u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (fire),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .o_complete  (complete),
        .o_codepoint (codepoint)
    );

    tcbf_cluster_tracker #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (fire),
        .i_complete  (complete),
        .i_codepoint (codepoint),
        .i_last      (r_in_last),
        .o_push      (push),
        .o_pos0      (pos0),
        .o_pos1      (pos1)
    );

    tcbf_out_buffer #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_out_buffer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_pos0     (pos0),
        .i_pos1     (pos1),
        .i_ready    (i_result_ready),
        .o_status   (buf_status),
        .o_valid    (o_result_valid),
        .o_position (o_boundary_position),
        .o_final    (o_final_boundary)
    );

    a_spill_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_status.spill_valid |-> buf_status.out_valid)
        else $error("Spill register holds a boundary while the result register is empty.");

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid1 |-> (push.valid0 && fire))
        else $error("Second boundary pushed without a first one.");

    a_second_spills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid1 |=> buf_status.spill_valid)
        else $error("Second boundary of an item was not kept.");

    a_last_has_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_last) |-> (push.valid0 && (push.fin0 || push.fin1)))
        else $error("Final byte of the text produced no final boundary.");

endmodule

>>> sv/tcbf_utf8_decoder.sv
// UTF-8 decoder of the Thai cluster boundary finder: gathers one code point.
// Depends on tcbf_pkg.
`timescale 1ns / 1ps

module tcbf_utf8_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [7:0]                    i_byte,
    input  logic                          i_last,
    output logic                          o_complete,
    output logic [tcbf_pkg::CP_WIDTH-1:0] o_codepoint
);
    import tcbf_pkg::*;

    logic [1:0]          r_pending, n_pending;
    logic [CP_WIDTH-1:0] r_partial, n_partial;

    always_comb begin
        n_pending   = r_pending;
        n_partial   = r_partial;
        o_complete  = 1'b0;
        o_codepoint = {{(CP_WIDTH-8){1'b0}}, i_byte};
        if (r_pending == 2'd0) begin
            if (i_byte[7] == 1'b0) begin
                o_complete = 1'b1;
            end else if (i_byte[7:5] == 3'b110) begin
                n_partial = {{(CP_WIDTH-5){1'b0}}, i_byte[4:0]};
                n_pending = 2'd1;
            end else if (i_byte[7:4] == 4'b1110) begin
                n_partial = {{(CP_WIDTH-4){1'b0}}, i_byte[3:0]};
                n_pending = 2'd2;
            end else if (i_byte[7:3] == 5'b11110) begin
                n_partial = {{(CP_WIDTH-3){1'b0}}, i_byte[2:0]};
                n_pending = 2'd3;
            end else begin
                o_complete = 1'b1;
            end
        end else begin
            n_partial = {r_partial[CP_WIDTH-7:0], i_byte[5:0]};
            n_pending = r_pending - 2'd1;
            if (r_pending == 2'd1) begin
                o_complete  = 1'b1;
                o_codepoint = n_partial;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_partial <= '0;
        end else if (i_step) begin
            if (i_last) begin
                r_pending <= 2'd0;
                r_partial <= '0;
            end else begin
                r_pending <= n_pending;
                r_partial <= n_partial;
            end
        end
    end

endmodule

>>> sv/tcbf_cluster_tracker.sv
// Cluster tracker of the Thai cluster boundary finder: phase, byte count and
// the up to two boundaries caused by one byte. Depends on tcbf_pkg.
`timescale 1ns / 1ps

module tcbf_cluster_tracker #(
    parameter int unsigned POSITION_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_complete,
    input  logic [tcbf_pkg::CP_WIDTH-1:0] i_codepoint,
    input  logic                          i_last,
    output tcbf_pkg::t_push               o_push,
    output logic [POSITION_WIDTH-1:0]     o_pos0,
    output logic [POSITION_WIDTH-1:0]     o_pos1
);
    import tcbf_pkg::*;

    t_phase                    r_phase, n_phase;
    logic [POSITION_WIDTH-1:0] r_seen, n_seen;
    logic [POSITION_WIDTH-1:0] r_open_end, n_open_end;

    t_cp_class cls;
    t_phase    join_phase;
    t_phase    start_phase;
    logic      in_cluster;
    logic      joins;
    logic      a_valid;
    logic      bc_valid;

    always_comb begin
        cls        = cp_class(i_codepoint);
        n_seen     = (&r_seen) ? r_seen : r_seen + 1'b1;
        in_cluster = 1'b1;
        joins      = 1'b0;
        join_phase = PH_IDLE;
        unique case (r_phase)
            PH_LEAD: begin
                joins      = (cls == CL_CONS);
                join_phase = PH_LEAD_C1;
            end
            PH_LEAD_C1: begin
                joins      = (cls == CL_CONS) || (cls == CL_MARK);
                join_phase = PH_LEAD_MARKS;
            end
            PH_LEAD_MARKS: begin
                joins      = (cls == CL_MARK);
                join_phase = PH_LEAD_MARKS;
            end
            PH_CONS_C1: begin
                joins      = (cls == CL_CONS) || (cls == CL_MARK) || (cls == CL_FOLLOW);
                join_phase = PH_CONS_MARKS;
            end
            PH_CONS_MARKS: begin
                joins      = (cls == CL_MARK) || (cls == CL_FOLLOW);
                join_phase = PH_CONS_MARKS;
            end
            default: begin
                in_cluster = 1'b0;
            end
        endcase

        case (cls)
            CL_LEAD: start_phase = PH_LEAD;
            CL_CONS: start_phase = PH_CONS_C1;
            default: start_phase = PH_IDLE;
        endcase

        a_valid    = 1'b0;
        bc_valid   = 1'b0;
        n_phase    = in_cluster ? r_phase : PH_IDLE;
        n_open_end = r_open_end;
        if (i_complete) begin
            n_open_end = n_seen;
            if (in_cluster && joins) begin
                n_phase = join_phase;
            end else begin
                a_valid = in_cluster;
                n_phase = start_phase;
            end
            bc_valid = (n_phase == PH_IDLE) || i_last;
        end else if (i_last) begin
            a_valid  = in_cluster;
            bc_valid = 1'b1;
        end

        o_push = '0;
        o_pos0 = n_seen;
        o_pos1 = n_seen;
        if (i_step) begin
            if (a_valid) begin
                o_pos0        = r_open_end;
                o_push.valid0 = 1'b1;
                o_push.fin0   = 1'b0;
                o_push.valid1 = bc_valid;
                o_push.fin1   = i_last;
            end else begin
                o_push.valid0 = bc_valid;
                o_push.fin0   = i_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_seen     <= '0;
            r_open_end <= '0;
        end else if (i_step) begin
            if (i_last) begin
                r_phase    <= PH_IDLE;
                r_seen     <= '0;
                r_open_end <= '0;
            end else begin
                r_phase    <= n_phase;
                r_seen     <= n_seen;
                r_open_end <= n_open_end;
            end
        end
    end

endmodule

>>> sv/tcbf_out_buffer.sv
// Result register of the Thai cluster boundary finder, with a second register
// for the other boundary when one byte closes two. Depends on tcbf_pkg.
`timescale 1ns / 1ps

module tcbf_out_buffer #(
    parameter int unsigned POSITION_WIDTH = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tcbf_pkg::t_push           i_push,
    input  logic [POSITION_WIDTH-1:0] i_pos0,
    input  logic [POSITION_WIDTH-1:0] i_pos1,
    input  logic                      i_ready,
    output tcbf_pkg::t_buf_status     o_status,
    output logic                      o_valid,
    output logic [POSITION_WIDTH-1:0] o_position,
    output logic                      o_final
);
    import tcbf_pkg::*;

    logic                      r_out_valid;
    logic [POSITION_WIDTH-1:0] r_out_pos;
    logic                      r_out_fin;
    logic                      r_spill_valid;
    logic [POSITION_WIDTH-1:0] r_spill_pos;
    logic                      r_spill_fin;
    logic                      pop;

    assign pop = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_spill_valid <= 1'b0;
        end else if (r_spill_valid) begin
            if (pop) begin
                r_spill_valid <= 1'b0;
            end
        end else if (i_push.valid0) begin
            r_out_valid   <= 1'b1;
            r_spill_valid <= i_push.valid1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_spill_valid) begin
            if (pop) begin
                r_out_pos <= r_spill_pos;
                r_out_fin <= r_spill_fin;
            end
        end else if (i_push.valid0) begin
            r_out_pos   <= i_pos0;
            r_out_fin   <= i_push.fin0;
            r_spill_pos <= i_pos1;
            r_spill_fin <= i_push.fin1;
        end
    end

    assign o_status.out_valid   = r_out_valid;
    assign o_status.spill_valid = r_spill_valid;
    assign o_valid              = r_out_valid;
    assign o_position           = r_out_pos;
    assign o_final              = r_out_fin;

endmodule
